@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define MTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/mtf_pkg.sv @@
// Package with the types and constants of the move-to-front order list.
package mtf_pkg;

    localparam int ELEM_W = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int unsigned RESET_COUNT = 256;

    localparam logic [0:0] REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_MOVE1 = 5'b00100,
        ST_MOVE2 = 5'b01000,
        ST_MOVE3 = 5'b10000
    } state_t;

    typedef struct packed {
        logic              init_req;
        logic [ELEM_W-1:0] count;
    } cfg_t;

endpackage

@@ sv/mtf_link_ram.sv @@
// Single-port synchronous link memory with a registered read port.
module mtf_link_ram #(
    parameter int DEPTH = 257,
    parameter int AW = 9,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ sv/mtf_cfg.sv @@
// APB register block holding the element count of the order list.
module mtf_cfg #(
    parameter int MAX_ELEMENTS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtf_pkg::PADDR_W-1:0] paddr,
    input  logic [mtf_pkg::PDATA_W-1:0] pwdata,
    output logic [mtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output mtf_pkg::cfg_t               cfg
);

    localparam int unsigned CountLimit = (MAX_ELEMENTS < 511) ? MAX_ELEMENTS : 511;
    localparam int unsigned ResetCount =
        (mtf_pkg::RESET_COUNT < CountLimit) ? mtf_pkg::RESET_COUNT : CountLimit;

    logic [mtf_pkg::ELEM_W-1:0] count_reg;
    logic [mtf_pkg::ELEM_W-1:0] count_next;
    logic [mtf_pkg::ELEM_W-1:0] wr_value;
    logic                       sel_count;
    logic                       wr_en;

    assign sel_count = (paddr[2] == mtf_pkg::REG_ELEMENT_COUNT);
    assign wr_en = psel && penable && pwrite && sel_count;
    assign wr_value = pwdata[mtf_pkg::ELEM_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
        begin
            if (wr_value == '0)
            begin
                count_next = mtf_pkg::ELEM_W'(1);
            end
            else if (32'(wr_value) > CountLimit)
            begin
                count_next = mtf_pkg::ELEM_W'(CountLimit);
            end
            else
            begin
                count_next = wr_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= mtf_pkg::ELEM_W'(ResetCount);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = sel_count ? mtf_pkg::PDATA_W'(count_reg) : '0;
    assign cfg.init_req = wr_en;
    assign cfg.count = count_reg;

endmodule

@@ sv/move_to_front_order_list_core.sv @@
// Top level of the move-to-front order list with its link memories and sequencer.
//
// Channel   Direction  Signals
// command   in         start, busy, element
// result    out        done, least_recent, bad_element
// config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A valid move takes one memory read at acceptance and three write steps, in ST_MOVE1,
// ST_MOVE2 and ST_MOVE3, on the single-port next and previous link memories; its
// result strobe follows ST_MOVE3 and the next transaction is taken back in ST_IDLE.
// A bad element or the element already at the front gives its result in the next cycle.
// After reset and after each element_count write a clearing pass rewrites every address
// 0 to MAX_ELEMENTS of both link memories; busy stays high during it.
// Results are not held: each is shown for one cycle and the receiver cannot stall it.
module move_to_front_order_list_core #(
    parameter int MAX_ELEMENTS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mtf_pkg::ELEM_W-1:0]  element,
    output logic                        done,
    output logic [mtf_pkg::ELEM_W-1:0]  least_recent,
    output logic                        bad_element,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtf_pkg::PADDR_W-1:0] paddr,
    input  logic [mtf_pkg::PDATA_W-1:0] pwdata,
    output logic [mtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int Depth = MAX_ELEMENTS + 1;
    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int LW = $clog2(MAX_ELEMENTS + 2);

    mtf_pkg::cfg_t  cfg;
    mtf_pkg::state_t state_reg, state_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] e_reg, e_next;
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg, back_next;
    logic          done_reg, done_next;
    logic          bad_reg, bad_next;
    logic [mtf_pkg::ELEM_W-1:0] lr_reg, lr_next;

    logic          nx_en, nx_we, pv_en, pv_we;
    logic [AW-1:0] nx_addr, pv_addr;
    logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic          accept;
    logic          in_bad;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] p_safe, n_safe;
    logic [LW-1:0] idx_l;
    logic          idx_in_range;

    mtf_cfg #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cfg(cfg)
    );

    mtf_link_ram #(
        .DEPTH(Depth),
        .AW(AW),
        .DW(LW)
    ) u_next_ram (
        .clk(clk),
        .en(nx_en),
        .we(nx_we),
        .addr(nx_addr),
        .wdata(nx_wdata),
        .rdata(nx_rdata)
    );

    mtf_link_ram #(
        .DEPTH(Depth),
        .AW(AW),
        .DW(LW)
    ) u_prev_ram (
        .clk(clk),
        .en(pv_en),
        .we(pv_we),
        .addr(pv_addr),
        .wdata(pv_wdata),
        .rdata(pv_rdata)
    );

    assign busy = (state_reg != mtf_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign in_bad = (element == '0) || (element > cfg.count);
    assign in_addr = AW'(element);

    assign p_safe = (pv_rdata <= LW'(MAX_ELEMENTS)) ? AW'(pv_rdata) : '0;
    assign n_safe = (nx_rdata <= LW'(MAX_ELEMENTS)) ? AW'(nx_rdata) : '0;

    assign idx_l = LW'(idx_reg);
    assign idx_in_range = (idx_l != '0) && (idx_l <= LW'(cfg.count));

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        e_next = e_reg;
        front_next = front_reg;
        back_next = back_reg;
        done_next = 1'b0;
        bad_next = bad_reg;
        lr_next = lr_reg;
        nx_en = 1'b0;
        nx_we = 1'b0;
        nx_addr = e_reg;
        nx_wdata = '0;
        pv_en = 1'b0;
        pv_we = 1'b0;
        pv_addr = e_reg;
        pv_wdata = '0;
        case (state_reg)
            mtf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    nx_en = 1'b1;
                    nx_addr = in_addr;
                    pv_en = 1'b1;
                    pv_addr = in_addr;
                    e_next = in_addr;
                    if (in_bad || (in_addr == front_reg))
                    begin
                        done_next = 1'b1;
                        bad_next = in_bad;
                        lr_next = mtf_pkg::ELEM_W'(back_reg);
                    end
                    else
                    begin
                        state_next = mtf_pkg::ST_MOVE1;
                    end
                end
            end
            mtf_pkg::ST_INIT:
            begin
                nx_en = 1'b1;
                nx_we = 1'b1;
                nx_addr = idx_reg;
                nx_wdata = idx_in_range ? (idx_l + LW'(1)) : '0;
                pv_en = 1'b1;
                pv_we = 1'b1;
                pv_addr = idx_reg;
                pv_wdata = idx_in_range ? (idx_l - LW'(1)) : '0;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(MAX_ELEMENTS))
                begin
                    state_next = mtf_pkg::ST_IDLE;
                    front_next = AW'(1);
                    back_next = AW'(cfg.count);
                end
            end
            mtf_pkg::ST_MOVE1:
            begin
                nx_en = 1'b1;
                nx_we = 1'b1;
                nx_addr = p_safe;
                nx_wdata = LW'(n_safe);
                if (e_reg == back_reg)
                begin
                    back_next = p_safe;
                end
                else
                begin
                    pv_en = 1'b1;
                    pv_we = 1'b1;
                    pv_addr = n_safe;
                    pv_wdata = LW'(p_safe);
                end
                state_next = mtf_pkg::ST_MOVE2;
            end
            mtf_pkg::ST_MOVE2:
            begin
                nx_en = 1'b1;
                nx_we = 1'b1;
                nx_addr = e_reg;
                nx_wdata = LW'(front_reg);
                pv_en = 1'b1;
                pv_we = 1'b1;
                pv_addr = front_reg;
                pv_wdata = LW'(e_reg);
                state_next = mtf_pkg::ST_MOVE3;
            end
            mtf_pkg::ST_MOVE3:
            begin
                pv_en = 1'b1;
                pv_we = 1'b1;
                pv_addr = e_reg;
                pv_wdata = '0;
                front_next = e_reg;
                done_next = 1'b1;
                bad_next = 1'b0;
                lr_next = mtf_pkg::ELEM_W'(back_reg);
                state_next = mtf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mtf_pkg::ST_IDLE;
            end
        endcase
        if (cfg.init_req)
        begin
            state_next = mtf_pkg::ST_INIT;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtf_pkg::ST_INIT;
            idx_reg <= '0;
            front_reg <= AW'(1);
            back_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            front_reg <= front_next;
            back_reg <= back_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        bad_reg <= bad_next;
        lr_reg <= lr_next;
    end

    assign done = done_reg;
    assign least_recent = lr_reg;
    assign bad_element = bad_reg;

endmodule

@@ sv/mtf_checker.sv @@
// Port-level checker for the move-to-front order list and its bind statement.
`include "assert_macros.svh"

module mtf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [mtf_pkg::ELEM_W-1:0]  least_recent,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mtf_pkg::PADDR_W-1:0] paddr,
    input logic                        pready
);

    logic cfg_count_wr;

    assign cfg_count_wr = psel && penable && pwrite && pready
        && (paddr[2] == mtf_pkg::REG_ELEMENT_COUNT);

    // An accepted transaction either reports at once or keeps the block busy.
    `MTF_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, done || busy)
    // The back of the order is always a real element.
    `MTF_ASSERT_SAME(a_result_nonzero, clk, rst_n, done, least_recent != '0)
    // A count write starts the clearing pass, so no transaction is taken next cycle.
    `MTF_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_count_wr, busy)
    // The configuration port never inserts wait states.
    `MTF_ASSERT_SAME(a_pready_high, clk, rst_n, psel, pready)

endmodule

bind move_to_front_order_list_core mtf_checker u_mtf_checker (.*);

@@ test/move_to_front_order_list_core_tb.sv @@
// Testbench for the move-to-front order list with a recency-order scoreboard.
module move_to_front_order_list_core_tb;

    localparam int unsigned MAX_ELEMENTS = 256;
    localparam int MAX_GAP = 18;
    localparam int PHASE_ITEMS = 123;
    localparam int REPORT_LIMIT = 10;

    class recency_scoreboard;
        int unsigned next_l[0:MAX_ELEMENTS];
        int unsigned prev_l[0:MAX_ELEMENTS];
        int unsigned front_elem;
        int unsigned back_elem;
        int unsigned count;
        logic [mtf_pkg::ELEM_W-1:0] exp_least_recent[$];
        logic exp_bad[$];
        int failures;

        function new();
            failures = 0;
            set_count(mtf_pkg::ELEM_W'(mtf_pkg::RESET_COUNT));
        endfunction

        function void set_count(logic [mtf_pkg::ELEM_W-1:0] value);
            if (value == 0)
                count = 1;
            else if (value > MAX_ELEMENTS)
                count = MAX_ELEMENTS;
            else
                count = 32'(value);
            for (int i = 0; i <= MAX_ELEMENTS; i++)
            begin
                next_l[i] = 0;
                prev_l[i] = 0;
            end
            for (int unsigned i = 1; i <= count; i++)
            begin
                next_l[i] = i + 1;
                prev_l[i] = i - 1;
            end
            front_elem = 1;
            back_elem = count;
        endfunction

        function int unsigned clip(int unsigned v);
            return (v <= MAX_ELEMENTS) ? v : 0;
        endfunction

        function void note_move(logic [mtf_pkg::ELEM_W-1:0] e);
            int unsigned idx;
            int unsigned p;
            int unsigned n;
            logic bad;
            idx = 32'(e);
            bad = (idx == 0) || (idx > count);
            if (!bad && idx != front_elem)
            begin
                p = clip(prev_l[idx]);
                n = clip(next_l[idx]);
                next_l[p] = n;
                if (idx == back_elem)
                    back_elem = p;
                else
                    prev_l[n] = p;
                next_l[idx] = front_elem;
                prev_l[clip(front_elem)] = idx;
                prev_l[idx] = 0;
                front_elem = idx;
            end
            exp_least_recent.push_back(back_elem[mtf_pkg::ELEM_W-1:0]);
            exp_bad.push_back(bad);
        endfunction

        function void complain(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_least_recent(logic [mtf_pkg::ELEM_W-1:0] lr, logic bad);
            logic [mtf_pkg::ELEM_W-1:0] want_lr;
            logic want_bad;
            if (exp_least_recent.size() == 0)
            begin
                complain($sformatf("unexpected transaction: least_recent=%0d bad_element=%b",
                                   lr, bad));
            end
            else
            begin
                want_lr = exp_least_recent.pop_front();
                want_bad = exp_bad.pop_front();
                if (lr !== want_lr)
                    complain($sformatf("least_recent mismatch: expected %0d, got %0d",
                                       want_lr, lr));
                if (bad !== want_bad)
                    complain($sformatf("bad_element mismatch: expected %b, got %b",
                                       want_bad, bad));
            end
        endfunction

        function void check_leftover();
            if (exp_least_recent.size() != 0)
                complain($sformatf("%0d expected transactions never arrived",
                                   exp_least_recent.size()));
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [mtf_pkg::ELEM_W-1:0]   element;
    logic                         done;
    logic [mtf_pkg::ELEM_W-1:0]   least_recent;
    logic                         bad_element;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mtf_pkg::PADDR_W-1:0]  paddr;
    logic [mtf_pkg::PDATA_W-1:0]  pwdata;
    logic [mtf_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    recency_scoreboard sb;

    move_to_front_order_list_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .element(element),
        .done(done),
        .least_recent(least_recent),
        .bad_element(bad_element),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_least_recent(least_recent, bad_element);
            if (start && !busy)
                sb.note_move(element);
        end
    end

    task automatic send_move(input logic [mtf_pkg::ELEM_W-1:0] e, input int gap);
        start <= 1'b1;
        element <= e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.exp_least_recent.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_count(input logic [mtf_pkg::PDATA_W-1:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {mtf_pkg::REG_ELEMENT_COUNT, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_count(value[mtf_pkg::ELEM_W-1:0]);
    endtask

    function automatic logic [mtf_pkg::ELEM_W-1:0] pick_element();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return sb.back_elem[mtf_pkg::ELEM_W-1:0];
        else if (roll < 15)
            return sb.front_elem[mtf_pkg::ELEM_W-1:0];
        else if (roll < 22 || sb.count >= 511)
            return '0;
        else if (roll < 32)
            return mtf_pkg::ELEM_W'($urandom_range(sb.count + 1, 511));
        else
            return mtf_pkg::ELEM_W'($urandom_range(1, sb.count));
    endfunction

    task automatic run_phase(input logic [mtf_pkg::PDATA_W-1:0] count_value,
                             input int n_items);
        int burst_left;
        int gap;
        burst_left = 0;
        write_count(count_value);
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 19) == 0)
                    burst_left = $urandom_range(10, 40);
            end
            send_move(pick_element(), gap);
            if (i == n_items / 2 || $urandom_range(0, 79) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [mtf_pkg::ELEM_W-1:0] full_list[] = '{9'd1, 9'd0, 9'd257, 9'd511, 9'd256,
                                                   9'd256, 9'd255, 9'd1, 9'd128, 9'd3,
                                                   9'd2, 9'h1AA, 9'h155};
        logic [mtf_pkg::ELEM_W-1:0] pair_list[] = '{9'd2, 9'd2, 9'd1, 9'd1, 9'd3, 9'd2};
        logic [mtf_pkg::PDATA_W-1:0] phase_counts[] = '{32'd300, 32'd3, 32'd2, 32'd1,
                                                        32'hFFFF_FE00, 32'd17, 32'd64,
                                                        32'd256, 32'd0, 32'd0};
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        element = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (full_list[i])
            send_move(full_list[i], $urandom_range(0, 3));
        write_count(32'd1);
        send_move(9'd1, 0);
        send_move(9'd2, 1);
        send_move(9'd0, 0);
        write_count(32'd2);
        foreach (pair_list[i])
            send_move(pair_list[i], i % 2);
        write_count(32'd0);
        send_move(9'd1, 0);

        phase_counts[8] = $urandom_range(1, 256);
        phase_counts[9] = $urandom_range(0, 511);
        foreach (phase_counts[i])
            run_phase(phase_counts[i], PHASE_ITEMS);

        wait_drained();
        repeat (8) @(posedge clk);
        sb.check_leftover();
        if (sb.failures == 0)
            $display("PASS move_to_front_order_list_core");
        else
            $display("FAIL move_to_front_order_list_core");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL move_to_front_order_list_core");
        $finish;
    end

endmodule
